@@ rtl/core/deq_pkg.sv @@
// deq_pkg: shared types and constants for the double-ended queue
// no dependencies; imported by deq_store, deq_ctrl and double_ended_queue_top
`timescale 1ns / 1ps

package deq_pkg;

  // ring depth; index arithmetic wraps by truncation, so this stays a power of two
  localparam int Depth = 16;
  localparam int IdxW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);
  localparam int DataW = 32;

  typedef enum logic [1:0] {
    KindPushFront = 2'd0,
    KindPushBack  = 2'd1,
    KindPopFront  = 2'd2,
    KindPopBack   = 2'd3
  } deq_kind_e;

  typedef enum logic [1:0] {
    StDone  = 2'd0,
    StEmpty = 2'd1,
    StFull  = 2'd2
  } deq_status_e;

  typedef struct packed {
    deq_kind_e                kind;
    logic signed [DataW-1:0]  value;
  } deq_in_t;

  typedef struct packed {
    deq_status_e              status;
    logic signed [DataW-1:0]  popped;
    logic [CntW-1:0]          occupancy;
  } deq_out_t;

  // one access to the slot memory
  typedef struct packed {
    logic             we;
    logic             re;
    logic [IdxW-1:0]  addr;
    logic [DataW-1:0] wdata;
  } deq_mem_req_t;

  // result fields that do not come from the memory
  typedef struct packed {
    deq_status_e      status;
    logic             pop_ok;
    logic [CntW-1:0]  occupancy;
  } deq_meta_t;

endpackage

@@ rtl/core/deq_store.sv @@
// deq_store: slot memory of the queue, one port, registered read data
// depends on deq_pkg
`timescale 1ns / 1ps

module deq_store (
  input  logic                 clk_i,
  input  deq_pkg::deq_mem_req_t req_i,
  output logic [deq_pkg::DataW-1:0] rdata_o
);
  import deq_pkg::*;

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/deq_ctrl.sv @@
// deq_ctrl: front index and entry count, slot address and result status
// depends on deq_pkg
`timescale 1ns / 1ps

module deq_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  deq_pkg::deq_in_t      in_i,
  output deq_pkg::deq_mem_req_t req_o,
  output deq_pkg::deq_meta_t    meta_o
);
  import deq_pkg::*;

  logic [IdxW-1:0] front_q, front_d;
  logic [CntW-1:0] count_q, count_d;
  deq_meta_t       meta_q, meta_d;
  logic            full, empty;
  logic [IdxW-1:0] back_pos;

  assign full     = (count_q == CntW'(Depth));
  assign empty    = (count_q == '0);
  assign back_pos = front_q + count_q[IdxW-1:0];

  always_comb begin
    front_d        = front_q;
    count_d        = count_q;
    req_o.we       = 1'b0;
    req_o.re       = 1'b0;
    req_o.addr     = front_q;
    req_o.wdata    = in_i.value;
    meta_d.status  = StDone;
    meta_d.pop_ok  = 1'b0;
    case (in_i.kind)
      KindPushFront: begin
        if (full) begin
          meta_d.status = StFull;
        end else begin
          front_d    = front_q - 1'b1;
          count_d    = count_q + 1'b1;
          req_o.we   = accept_i;
          req_o.addr = front_q - 1'b1;
        end
      end
      KindPushBack: begin
        if (full) begin
          meta_d.status = StFull;
        end else begin
          count_d    = count_q + 1'b1;
          req_o.we   = accept_i;
          req_o.addr = back_pos;
        end
      end
      KindPopFront: begin
        if (empty) begin
          meta_d.status = StEmpty;
        end else begin
          front_d       = front_q + 1'b1;
          count_d       = count_q - 1'b1;
          req_o.re      = accept_i;
          meta_d.pop_ok = 1'b1;
        end
      end
      KindPopBack: begin
        if (empty) begin
          meta_d.status = StEmpty;
        end else begin
          count_d       = count_q - 1'b1;
          req_o.re      = accept_i;
          req_o.addr    = back_pos - 1'b1;
          meta_d.pop_ok = 1'b1;
        end
      end
      default: begin
        meta_d.status = StDone;
      end
    endcase
    meta_d.occupancy = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
      meta_q  <= '0;
    end else if (accept_i) begin
      front_q <= front_d;
      count_q <= count_d;
      meta_q  <= meta_d;
    end
  end

  assign meta_o = meta_q;

endmodule

@@ rtl/core/double_ended_queue_top.sv @@
// double_ended_queue_top: double-ended queue of signed 32-bit values in a ring store
// depends on deq_pkg, deq_ctrl, deq_store
//
//   channel | direction | handshake               | payload
//   in      | request   | in_valid_i / in_stall_o  | in_data_i  (kind, value)
//   out     | result    | out_valid_o / out_stall_i| out_data_o (status, popped, occupancy)
//
// one request per cycle while the result is not stalled; its result appears in the cycle
// after acceptance, set by the registered read data of the slot memory.
// the pointer update and the slot access both happen at the accepting edge, so
// back-to-back requests on the same slot need no forwarding.
// reset clears the front index and entry count; slot contents stay undefined.
// a stalled result holds, and a new request is taken only when it leaves.
`timescale 1ns / 1ps

module double_ended_queue_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  deq_pkg::deq_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output deq_pkg::deq_out_t out_data_o
);
  import deq_pkg::*;

  logic             accept;
  logic             out_valid_q, out_valid_d;
  deq_mem_req_t     mem_req;
  deq_meta_t        meta;
  logic [DataW-1:0] rdata;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  deq_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_i     (in_data_i),
    .req_o    (mem_req),
    .meta_o   (meta)
  );

  deq_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_data_o.status    = meta.status;
  assign out_data_o.occupancy = meta.occupancy;
  // empty pop reads back all ones, a push reads back zero
  assign out_data_o.popped    = meta.pop_ok ? $signed(rdata) :
                                (meta.status == StEmpty) ? -32'sd1 : 32'sd0;

  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted request produced no result");

  a_occ_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.occupancy <= CntW'(Depth)))
    else $error("occupancy beyond depth");

  a_full_occ : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == StFull) |->
      (out_data_o.occupancy == CntW'(Depth) && out_data_o.popped == 32'sd0))
    else $error("dropped push with queue not full");

  a_empty_pop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == StEmpty) |->
      (out_data_o.occupancy == '0 && out_data_o.popped == -32'sd1))
    else $error("empty pop with entries held");

endmodule
